FILE: rtl/hmac_sha256_engine_defines.svh
// assertion macros for the hmac sha-256 engine
`ifndef HMAC_SHA256_ENGINE_DEFINES_SVH
`define HMAC_SHA256_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define HSE_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("hse: forbidden condition seen");

`define HSE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hse: same-cycle implication failed");

`define HSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hse: next-cycle implication failed");

`else

`define HSE_ASSERT_NEVER(lbl, cond)
`define HSE_ASSERT_NOW(lbl, ante, cons)
`define HSE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/hse_pkg.sv
// shared types, constants and sha-256 functions for the hmac engine
`timescale 1ns / 1ps
package hse_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int BLOCK_BYTES     = 64;
  localparam int BLOCK_BITS      = 512;
  localparam int CHAIN_BITS      = 256;
  localparam int FIFO_DEPTH      = 2;
  localparam logic [7:0] IPAD_BYTE = 8'h36;
  localparam logic [7:0] OPAD_BYTE = 8'h5c;
  localparam logic [7:0] PAD_MARK  = 8'h80;

  localparam logic ACT_KEY = 1'b0;
  localparam logic ACT_MSG = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_item;
  } item_t;

  typedef struct packed {
    logic core_start;
    logic core_busy;
    logic emitting;
  } back_stat_t;

  localparam logic [CHAIN_BITS-1:0] INIT_H = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

endpackage

FILE: rtl/hse_if.sv
// valid/ready channel interfaces for the hmac engine
`timescale 1ns / 1ps
interface hse_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last_item;
  modport source (output valid, action, data_byte, byte_valid, last_item, input ready);
  modport sink (input valid, action, data_byte, byte_valid, last_item, output ready);
endinterface

interface hse_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        word_last;
  logic        length_overflow;
  modport source (output valid, digest_word, word_last, length_overflow, input ready);
  modport sink (input valid, digest_word, word_last, length_overflow, output ready);
endinterface

FILE: rtl/hse_front.sv
// input front: takes beats and queues them for the back end
`timescale 1ns / 1ps
module hse_front (
  input  logic          clk,
  input  logic          rst_n,
  hse_in_if.sink        in_ch,
  output hse_pkg::item_t q_item,
  output logic          q_valid,
  input  logic          q_pop,
  output logic [1:0]    q_fill
);
  import hse_pkg::*;

  item_t      ent_r [0:FIFO_DEPTH-1];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;
  logic       push;
  logic       pop;
  item_t      in_item;

  assign in_ch.ready = (fill_r != 2'(FIFO_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (fill_r != 2'd0);
  assign pop         = q_pop && q_valid;
  assign q_item      = ent_r[rd_ptr_r];
  assign q_fill      = fill_r;

  always_comb begin
    in_item.action     = in_ch.action;
    in_item.data_byte  = in_ch.data_byte;
    in_item.byte_valid = in_ch.byte_valid;
    in_item.last_item  = in_ch.last_item;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end
endmodule

FILE: rtl/hse_core.sv
// sha-256 compression unit, one round per cycle
`timescale 1ns / 1ps
module hse_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [511:0] block,
  input  logic [255:0] chain_in,
  output logic         busy,
  output logic         done,
  output logic [255:0] digest
);
  import hse_pkg::*;

  logic [31:0]  w_r [0:15];
  logic [31:0]  v_r [0:7];
  logic [31:0]  h_r [0:7];
  logic [5:0]   rnd_r;
  logic         run_r;
  logic         fin_r;
  logic         done_r;
  logic [255:0] dig_r;
  logic [31:0]  t1;
  logic [31:0]  t2;
  logic [31:0]  w_new;

  always_comb begin
    t1 = v_r[7] + big_s1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
       + ROUND_K[rnd_r] + w_r[0];
    t2 = big_s0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
    w_new = w_r[0] + small_s0(w_r[1]) + w_r[9] + small_s1(w_r[14]);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < 16; i++) begin
        w_r[i] <= block[511 - 32*i -: 32];
      end
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= chain_in[255 - 32*i -: 32];
        h_r[i] <= chain_in[255 - 32*i -: 32];
      end
    end else if (run_r) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= w_new;
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
    if (fin_r) begin
      for (int i = 0; i < 8; i++) begin
        dig_r[255 - 32*i -: 32] <= h_r[i] + v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= 6'd0;
    end else begin
      done_r <= fin_r;
      fin_r  <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        rnd_r <= 6'd0;
      end else if (run_r) begin
        rnd_r <= rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end
    end
  end

  assign busy   = run_r || fin_r;
  assign done   = done_r;
  assign digest = dig_r;
endmodule

FILE: rtl/hse_back.sv
// back end: key and message sequencing, padding and digest output
`timescale 1ns / 1ps
module hse_back #(
  parameter int COUNT_WIDTH = hse_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hse_pkg::item_t     q_item,
  input  logic               q_valid,
  output logic               q_pop,
  hse_out_if.source          out_ch,
  output hse_pkg::back_stat_t stat
);
  import hse_pkg::*;

  localparam logic [4:0] ST_IDLE      = 5'd0;
  localparam logic [4:0] ST_BEGIN     = 5'd1;
  localparam logic [4:0] ST_KEYBYTE   = 5'd2;
  localparam logic [4:0] ST_KEYLAST   = 5'd3;
  localparam logic [4:0] ST_ENDKEY    = 5'd4;
  localparam logic [4:0] ST_ENDKEY2   = 5'd5;
  localparam logic [4:0] ST_MSGSTART  = 5'd6;
  localparam logic [4:0] ST_MSGBYTE   = 5'd7;
  localparam logic [4:0] ST_MSGLAST   = 5'd8;
  localparam logic [4:0] ST_INNERDONE = 5'd9;
  localparam logic [4:0] ST_OUTERFIN  = 5'd10;
  localparam logic [4:0] ST_FIN       = 5'd11;
  localparam logic [4:0] ST_CSTART    = 5'd12;
  localparam logic [4:0] ST_CWAIT     = 5'd13;
  localparam logic [4:0] ST_EMIT      = 5'd14;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_KEY  = 2'd1;
  localparam logic [1:0] PH_MSG  = 2'd2;

  localparam logic [1:0] BLK_KEY  = 2'd0;
  localparam logic [1:0] BLK_IPAD = 2'd1;
  localparam logic [1:0] BLK_OPAD = 2'd2;
  localparam logic [1:0] BLK_BUF  = 2'd3;

  localparam logic [1:0] FM_PAD  = 2'd0;
  localparam logic [1:0] FM_ZERO = 2'd1;
  localparam logic [1:0] FM_LEN  = 2'd2;

  localparam logic [6:0] RIDX_LAST = 7'(BLOCK_BYTES - 1);
  localparam logic [6:0] RIDX_LEN  = 7'(BLOCK_BYTES - 8);
  localparam logic [6:0] RIDX_HALF = 7'(BLOCK_BYTES / 2);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] CNT_BLOCK = COUNT_WIDTH'(BLOCK_BYTES);
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE   = COUNT_WIDTH'(1);
  localparam logic [63:0] OUTER_BITS = 64'((BLOCK_BYTES + 32) * 8);

  logic [4:0]             state_r;
  logic [4:0]             ret_r;
  logic [4:0]             fret_r;
  item_t                  it_r;
  logic [BLOCK_BITS-1:0]  key_r;
  logic [BLOCK_BITS-1:0]  buf_r;
  logic [CHAIN_BITS-1:0]  chain_r;
  logic [COUNT_WIDTH-1:0] kcnt_r;
  logic [COUNT_WIDTH-1:0] mcnt_r;
  logic                   khash_r;
  logic                   ovf_r;
  logic [1:0]             phase_r;
  logic [6:0]             ridx_r;
  logic [1:0]             blk_sel_r;
  logic [1:0]             fmode_r;
  logic [63:0]            len_r;
  logic [2:0]             lcnt_r;
  logic [2:0]             wcnt_r;
  logic                   ov_r;
  logic [31:0]            od_r;
  logic                   ol_r;
  logic                   oo_r;

  logic [BLOCK_BITS-1:0]  core_block;
  logic                   core_start;
  logic                   core_busy;
  logic                   core_done;
  logic [CHAIN_BITS-1:0]  core_digest;
  logic [7:0]             fin_byte;
  logic                   fin_feed;
  logic                   fin_final;
  logic                   emit_load;

  always_comb begin
    case (blk_sel_r)
      BLK_KEY:  core_block = key_r;
      BLK_IPAD: core_block = key_r ^ {BLOCK_BYTES{IPAD_BYTE}};
      BLK_OPAD: core_block = key_r ^ {BLOCK_BYTES{OPAD_BYTE}};
      BLK_BUF:  core_block = buf_r;
      default:  core_block = buf_r;
    endcase
  end

  always_comb begin
    fin_byte  = 8'd0;
    fin_feed  = 1'b1;
    fin_final = 1'b0;
    case (fmode_r)
      FM_PAD:  fin_byte = PAD_MARK;
      FM_ZERO: fin_feed = (ridx_r != RIDX_LEN);
      FM_LEN: begin
        fin_byte  = len_r[63:56];
        fin_final = (lcnt_r == 3'd7);
      end
      default: fin_feed = 1'b0;
    endcase
  end

  assign core_start = (state_r == ST_CSTART);
  assign q_pop      = (state_r == ST_IDLE) && q_valid;
  assign emit_load  = (state_r == ST_EMIT) && (!ov_r || out_ch.ready);

  hse_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (core_start),
    .block    (core_block),
    .chain_in (chain_r),
    .busy     (core_busy),
    .done     (core_done),
    .digest   (core_digest)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (emit_load) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_IDLE;
      key_r   <= '0;
      kcnt_r  <= '0;
      mcnt_r  <= '0;
      khash_r <= 1'b0;
      ovf_r   <= 1'b0;
      ridx_r  <= 7'd0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            it_r    <= q_item;
            state_r <= ST_BEGIN;
          end
        end
        ST_BEGIN: begin
          if (it_r.action == ACT_KEY) begin
            if (phase_r != PH_KEY) begin
              key_r   <= '0;
              kcnt_r  <= '0;
              khash_r <= 1'b0;
              ridx_r  <= 7'd0;
              phase_r <= PH_KEY;
            end
            state_r <= ST_KEYBYTE;
          end else if (phase_r == PH_KEY) begin
            state_r <= ST_ENDKEY;
          end else begin
            state_r <= ST_MSGSTART;
          end
        end
        ST_KEYBYTE: begin
          if (!it_r.byte_valid) begin
            state_r <= ST_KEYLAST;
          end else if (!khash_r && kcnt_r < CNT_BLOCK) begin
            key_r[{~kcnt_r[5:0], 3'b000} +: 8] <= it_r.data_byte;
            kcnt_r  <= kcnt_r + CNT_ONE;
            state_r <= ST_KEYLAST;
          end else if (!khash_r) begin
            chain_r   <= INIT_H;
            blk_sel_r <= BLK_KEY;
            ret_r     <= ST_KEYBYTE;
            khash_r   <= 1'b1;
            ridx_r    <= 7'd0;
            state_r   <= ST_CSTART;
          end else begin
            buf_r <= {buf_r[BLOCK_BITS-9:0], it_r.data_byte};
            if (kcnt_r != CNT_MAX) begin
              kcnt_r <= kcnt_r + CNT_ONE;
            end
            if (ridx_r == RIDX_LAST) begin
              ridx_r    <= 7'd0;
              blk_sel_r <= BLK_BUF;
              ret_r     <= ST_KEYLAST;
              state_r   <= ST_CSTART;
            end else begin
              ridx_r  <= ridx_r + 7'd1;
              state_r <= ST_KEYLAST;
            end
          end
        end
        ST_KEYLAST: begin
          state_r <= it_r.last_item ? ST_ENDKEY : ST_IDLE;
        end
        ST_ENDKEY: begin
          if (khash_r) begin
            len_r   <= 64'(kcnt_r) << 3;
            fmode_r <= FM_PAD;
            lcnt_r  <= 3'd0;
            fret_r  <= ST_ENDKEY2;
            state_r <= ST_FIN;
          end else begin
            ridx_r  <= 7'd0;
            phase_r <= PH_IDLE;
            state_r <= (it_r.action == ACT_MSG) ? ST_MSGSTART : ST_IDLE;
          end
        end
        ST_ENDKEY2: begin
          key_r   <= {chain_r, {(BLOCK_BITS - CHAIN_BITS){1'b0}}};
          khash_r <= 1'b0;
          ridx_r  <= 7'd0;
          phase_r <= PH_IDLE;
          state_r <= (it_r.action == ACT_MSG) ? ST_MSGSTART : ST_IDLE;
        end
        ST_MSGSTART: begin
          if (phase_r != PH_MSG) begin
            chain_r   <= INIT_H;
            blk_sel_r <= BLK_IPAD;
            ret_r     <= ST_MSGBYTE;
            ridx_r    <= 7'd0;
            mcnt_r    <= '0;
            ovf_r     <= 1'b0;
            phase_r   <= PH_MSG;
            state_r   <= ST_CSTART;
          end else begin
            state_r <= ST_MSGBYTE;
          end
        end
        ST_MSGBYTE: begin
          if (!it_r.byte_valid) begin
            state_r <= ST_MSGLAST;
          end else begin
            buf_r <= {buf_r[BLOCK_BITS-9:0], it_r.data_byte};
            if (mcnt_r != CNT_MAX) begin
              mcnt_r <= mcnt_r + CNT_ONE;
            end else begin
              ovf_r <= 1'b1;
            end
            if (ridx_r == RIDX_LAST) begin
              ridx_r    <= 7'd0;
              blk_sel_r <= BLK_BUF;
              ret_r     <= ST_MSGLAST;
              state_r   <= ST_CSTART;
            end else begin
              ridx_r  <= ridx_r + 7'd1;
              state_r <= ST_MSGLAST;
            end
          end
        end
        ST_MSGLAST: begin
          if (it_r.last_item) begin
            len_r   <= (64'(mcnt_r) + 64'(BLOCK_BYTES)) << 3;
            fmode_r <= FM_PAD;
            lcnt_r  <= 3'd0;
            fret_r  <= ST_INNERDONE;
            state_r <= ST_FIN;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_INNERDONE: begin
          buf_r[CHAIN_BITS-1:0] <= chain_r;
          ridx_r    <= RIDX_HALF;
          chain_r   <= INIT_H;
          blk_sel_r <= BLK_OPAD;
          ret_r     <= ST_OUTERFIN;
          state_r   <= ST_CSTART;
        end
        ST_OUTERFIN: begin
          len_r   <= OUTER_BITS;
          fmode_r <= FM_PAD;
          lcnt_r  <= 3'd0;
          fret_r  <= ST_EMIT;
          wcnt_r  <= 3'd0;
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (fmode_r == FM_PAD) begin
            fmode_r <= FM_ZERO;
          end else if (fmode_r == FM_ZERO && !fin_feed) begin
            fmode_r <= FM_LEN;
          end else if (fmode_r == FM_LEN) begin
            len_r  <= len_r << 8;
            lcnt_r <= lcnt_r + 3'd1;
          end
          if (fin_feed) begin
            buf_r <= {buf_r[BLOCK_BITS-9:0], fin_byte};
            if (ridx_r == RIDX_LAST) begin
              ridx_r    <= 7'd0;
              blk_sel_r <= BLK_BUF;
              ret_r     <= fin_final ? fret_r : ST_FIN;
              state_r   <= ST_CSTART;
            end else begin
              ridx_r <= ridx_r + 7'd1;
            end
          end
        end
        ST_CSTART: begin
          state_r <= ST_CWAIT;
        end
        ST_CWAIT: begin
          if (core_done) begin
            chain_r <= core_digest;
            state_r <= ret_r;
          end
        end
        ST_EMIT: begin
          if (emit_load) begin
            od_r   <= chain_r[{~wcnt_r, 5'b00000} +: 32];
            ol_r   <= (wcnt_r == 3'd7);
            oo_r   <= ovf_r;
            wcnt_r <= wcnt_r + 3'd1;
            if (wcnt_r == 3'd7) begin
              phase_r <= PH_IDLE;
              ridx_r  <= 7'd0;
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid           = ov_r;
  assign out_ch.digest_word     = od_r;
  assign out_ch.word_last       = ol_r;
  assign out_ch.length_overflow = oo_r;

  assign stat.core_start = core_start;
  assign stat.core_busy  = core_busy;
  assign stat.emitting   = (state_r == ST_EMIT);
endmodule

FILE: rtl/hmac_sha256_engine.sv
// HMAC-SHA256 engine: byte-serial key and message in, eight digest words out
//
// A two-beat input queue feeds a sequencer that handles one beat at a time.
// Every beat that completes a 64-byte block adds one compression: 64 rounds
// on the single shared round unit. The first message beat after a key adds
// one compression for the inner pad, and the last message beat runs the inner
// finish, the outer pad and the outer finish (three or four compressions in
// all) before the eight words leave through an output register.
`timescale 1ns / 1ps
`include "hmac_sha256_engine_defines.svh"
module hmac_sha256_engine #(
  parameter int COUNT_WIDTH = hse_pkg::COUNT_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  hse_in_if.sink     in_ch,
  hse_out_if.source  out_ch
);
  import hse_pkg::*;

  item_t      q_item;
  logic       q_valid;
  logic       q_pop;
  logic [1:0] q_fill;
  back_stat_t stat;

  hse_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_fill  (q_fill)
  );

  hse_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .out_ch  (out_ch),
    .stat    (stat)
  );

  `HSE_ASSERT_NEVER(a_fill_bound, q_fill > 2'(FIFO_DEPTH))
  `HSE_ASSERT_NOW(a_core_free_on_start, stat.core_start, !stat.core_busy)
  `HSE_ASSERT_NEXT(a_gap_after_last,
    out_ch.valid && out_ch.ready && out_ch.word_last, !out_ch.valid)
  `HSE_ASSERT_NOW(a_new_word_only_emitting,
    out_ch.valid && !$past(out_ch.valid), $past(stat.emitting))
endmodule
